/* hdl/itf_pkg.sv */
package itf_pkg;

  localparam int MAX_WIDTH_DEF     = 64;
  localparam int MAX_PRECISION_DEF = 50;

  localparam int VAL_W  = 64;
  // A 64-bit value needs at most 22 octal digits; decimal and hex need fewer.
  localparam int NDIG   = 22;
  localparam int NDIG_W = 5;

  localparam logic [2:0] FUNC_DEC    = 3'd0;
  localparam logic [2:0] FUNC_UNS    = 3'd1;
  localparam logic [2:0] FUNC_OCT    = 3'd2;
  localparam logic [2:0] FUNC_HEX_LO = 3'd3;
  localparam logic [2:0] FUNC_HEX_UP = 3'd4;
  localparam logic [2:0] FUNC_PTR    = 3'd5;
  localparam logic [2:0] FUNC_RSVD6  = 3'd6;
  localparam logic [2:0] FUNC_RSVD7  = 3'd7;

  localparam logic [2:0] SIZE_INT     = 3'd0;
  localparam logic [2:0] SIZE_CHAR    = 3'd1;
  localparam logic [2:0] SIZE_SHORT   = 3'd2;
  localparam logic [2:0] SIZE_LONG    = 3'd3;
  localparam logic [2:0] SIZE_LLONG   = 3'd4;
  localparam logic [2:0] SIZE_SIZET   = 3'd5;
  localparam logic [2:0] SIZE_INTMAX  = 3'd6;
  localparam logic [2:0] SIZE_UNKNOWN = 3'd7;

  localparam logic [1:0] SIGN_NONE  = 2'd0;
  localparam logic [1:0] SIGN_SPACE = 2'd1;
  localparam logic [1:0] SIGN_PLUS  = 2'd2;
  localparam logic [1:0] SIGN_BOTH  = 2'd3;

  localparam int SIGN_SPACE_BIT = 0;
  localparam int SIGN_PLUS_BIT  = 1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_X_LO  = 8'h78;

  typedef enum logic [1:0] {RADIX_8, RADIX_10, RADIX_16} radix_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP, ST_CONV, ST_NORM, ST_SETUP, ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    PH_NONE, PH_PAD_PRE, PH_SIGN, PH_PFX_ZERO, PH_PFX_X, PH_ZERO, PH_DIGIT, PH_PAD_POST
  } phase_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic norm;
  } conv_cmd_t;

  typedef struct packed {
    logic [3:0]        top_digit;
    logic [NDIG_W-1:0] ndig;
    logic              bits_done;
    logic              norm_done;
  } conv_sts_t;

  typedef struct packed {
    logic              load;
    logic              left;
    logic              fill_zero;
    logic              sign_on;
    logic [7:0]        sign_char;
    logic              prefix;
    logic              upper;
    logic [NDIG_W-1:0] ndig;
  } emit_job_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    if (d < 4'd10) begin
      return CH_ZERO + {4'd0, d};
    end
    return (upper ? CH_A_UP : CH_A_LO) + {4'd0, d} - 8'd10;
  endfunction

endpackage

/* hdl/itf_req_if.sv */
interface itf_req_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [2:0]  func;
  logic [2:0]  size_kind;
  logic [1:0]  sign_mode;
  logic        alt_form;
  logic        left_adjust;
  logic        zero_fill;
  logic [6:0]  width;
  logic [5:0]  precision;

  modport source (
    output valid, value, func, size_kind, sign_mode, alt_form, left_adjust, zero_fill,
           width, precision,
    input  ready
  );
  modport sink (
    input  valid, value, func, size_kind, sign_mode, alt_form, left_adjust, zero_fill,
           width, precision,
    output ready
  );
endinterface

/* hdl/itf_chr_if.sv */
interface itf_chr_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, out_char, last, input ready);
  modport sink (input valid, out_char, last, output ready);
endinterface

/* hdl/itf_conv.sv */
module itf_conv import itf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  conv_cmd_t          cmd,
  input  logic               pop,
  input  radix_t             radix,
  input  logic [VAL_W-1:0]   mag,
  output conv_sts_t          sts
);

  localparam int BC_W = $clog2(VAL_W + 1);

  logic [VAL_W-1:0]           mag_sr;
  logic [BC_W-1:0]            bit_cnt;
  logic [NDIG_W-1:0]          ndig;
  logic [NDIG-1:0][3:0]       digits;
  logic [NDIG-1:0][3:0]       lane_next;
  logic [NDIG:0]              carry;
  logic [4:0]                 base;
  logic [3:0]                 half;
  logic                       bits_done;
  logic                       norm_done;
  logic                       shifting;

  always_comb begin
    case (radix)
      RADIX_8: begin
        base = 5'd8;
        half = 4'd4;
      end
      RADIX_10: begin
        base = 5'd10;
        half = 4'd5;
      end
      default: begin
        base = 5'd16;
        half = 4'd8;
      end
    endcase
  end

  // Each digit lane doubles its digit and adds the carry from below; a digit
  // at or above half the radix wraps and carries into the next lane.
  always_comb begin
    logic [4:0] dbl;
    dbl = '0;
    carry[0] = mag_sr[VAL_W-1];
    for (int i = 0; i < NDIG; i++) begin
      carry[i+1] = (digits[i] >= half);
      dbl = {digits[i], carry[i]} - (carry[i+1] ? base : 5'd0);
      lane_next[i] = dbl[3:0];
    end
  end

  assign bits_done = (bit_cnt == '0);
  assign norm_done = (ndig == '0) || (digits[NDIG-1] != 4'd0);
  assign shifting  = (cmd.norm && !norm_done) || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt <= '0;
      ndig    <= '0;
    end else if (cmd.load) begin
      bit_cnt <= BC_W'(VAL_W);
      ndig    <= NDIG_W'(NDIG);
    end else if (cmd.conv && !bits_done) begin
      bit_cnt <= bit_cnt - 1'b1;
    end else if (cmd.norm && !norm_done) begin
      ndig <= ndig - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_sr <= mag;
      digits <= '0;
    end else if (cmd.conv && !bits_done) begin
      mag_sr <= {mag_sr[VAL_W-2:0], 1'b0};
      digits <= lane_next;
    end else if (shifting) begin
      digits <= {digits[NDIG-2:0], 4'd0};
    end
  end

  assign sts.top_digit = digits[NDIG-1];
  assign sts.ndig      = ndig;
  assign sts.bits_done = bits_done;
  assign sts.norm_done = norm_done;

endmodule

/* hdl/itf_emit.sv */
module itf_emit import itf_pkg::*; #(
  parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
  parameter int MAX_PRECISION = MAX_PRECISION_DEF,
  localparam int LEN_W        = $clog2(MAX_WIDTH + MAX_PRECISION + NDIG + 4),
  localparam int ZW           = $clog2(MAX_PRECISION + 2)
) (
  input  logic             clk,
  input  logic             rst,
  input  emit_job_t        job,
  input  logic [ZW-1:0]    zeros,
  input  logic [LEN_W-1:0] pad,
  input  logic [LEN_W-1:0] total,
  input  logic [3:0]       digit,
  output logic             pop,
  output logic             busy,
  itf_chr_if.source        chr
);

  logic [LEN_W-1:0]  pad_cnt;
  logic [LEN_W-1:0]  rem_cnt;
  logic [ZW-1:0]     zero_cnt;
  logic [NDIG_W-1:0] dig_cnt;
  logic              sign_pend;
  logic              pfx0_pend;
  logic              pfxx_pend;
  logic              left;
  logic              fill_zero;
  logic              upper;
  logic [7:0]        sign_char;
  logic              ovalid;
  logic [7:0]        ochar;
  logic              olast;
  phase_t            phase;
  logic [7:0]        char_sel;
  logic              fire;

  // The pieces of the field come out in a fixed order; the first one that
  // still has characters left is the one being sent.
  always_comb begin
    if (!left && pad_cnt != '0) begin
      phase = PH_PAD_PRE;
    end else if (sign_pend) begin
      phase = PH_SIGN;
    end else if (pfx0_pend) begin
      phase = PH_PFX_ZERO;
    end else if (pfxx_pend) begin
      phase = PH_PFX_X;
    end else if (zero_cnt != '0) begin
      phase = PH_ZERO;
    end else if (dig_cnt != '0) begin
      phase = PH_DIGIT;
    end else if (pad_cnt != '0) begin
      phase = PH_PAD_POST;
    end else begin
      phase = PH_NONE;
    end
  end

  always_comb begin
    case (phase)
      PH_PAD_PRE, PH_PAD_POST: char_sel = fill_zero ? CH_ZERO : CH_SPACE;
      PH_SIGN:                 char_sel = sign_char;
      PH_PFX_ZERO, PH_ZERO:    char_sel = CH_ZERO;
      PH_PFX_X:                char_sel = upper ? CH_X_UP : CH_X_LO;
      PH_DIGIT:                char_sel = digit_char(digit, upper);
      default:                 char_sel = CH_SPACE;
    endcase
  end

  assign busy = (phase != PH_NONE);
  assign fire = busy && (!ovalid || chr.ready);
  assign pop  = fire && (phase == PH_DIGIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_cnt   <= '0;
      rem_cnt   <= '0;
      zero_cnt  <= '0;
      dig_cnt   <= '0;
      sign_pend <= 1'b0;
      pfx0_pend <= 1'b0;
      pfxx_pend <= 1'b0;
      ovalid    <= 1'b0;
    end else begin
      if (job.load) begin
        pad_cnt   <= pad;
        rem_cnt   <= total;
        zero_cnt  <= zeros;
        dig_cnt   <= job.ndig;
        sign_pend <= job.sign_on;
        pfx0_pend <= job.prefix;
        pfxx_pend <= job.prefix;
      end else if (fire) begin
        rem_cnt <= rem_cnt - 1'b1;
        case (phase)
          PH_PAD_PRE, PH_PAD_POST: pad_cnt <= pad_cnt - 1'b1;
          PH_SIGN:                 sign_pend <= 1'b0;
          PH_PFX_ZERO:             pfx0_pend <= 1'b0;
          PH_PFX_X:                pfxx_pend <= 1'b0;
          PH_ZERO:                 zero_cnt <= zero_cnt - 1'b1;
          PH_DIGIT:                dig_cnt <= dig_cnt - 1'b1;
          default:                 ;
        endcase
      end
      if (fire) begin
        ovalid <= 1'b1;
      end else if (chr.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job.load) begin
      left      <= job.left;
      fill_zero <= job.fill_zero;
      upper     <= job.upper;
      sign_char <= job.sign_char;
    end
    if (fire) begin
      ochar <= char_sel;
      olast <= (rem_cnt == LEN_W'(1));
    end
  end

  assign chr.valid    = ovalid;
  assign chr.out_char = ochar;
  assign chr.last     = olast;

endmodule

/* hdl/integer_to_text_formatter.sv */
// Before the first character of an accepted request, the magnitude is formed, the
// bit-serial radix conversion runs, leading zero digits are stripped and the field
// is sized. Characters then leave one per cycle while the output is taken. A new
// request is taken once the last character has entered the output register.
// Reset (rst, synchronous) returns the sequencer to idle and drops any output.
module integer_to_text_formatter import itf_pkg::*; #(
  parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
  parameter int MAX_PRECISION = MAX_PRECISION_DEF
) (
  input  logic      clk,
  input  logic      rst,
  itf_req_if.sink   req,
  itf_chr_if.source chars
);

  localparam int LEN_W = $clog2(MAX_WIDTH + MAX_PRECISION + NDIG + 4);
  localparam int ZW    = $clog2(MAX_PRECISION + 2);

  state_t           state;
  state_t           state_next;

  logic [VAL_W-1:0] value_q;
  logic [2:0]       func_q;
  logic [2:0]       size_q;
  logic [1:0]       sign_mode_q;
  logic             alt_q;
  logic             left_q;
  logic             fill_q;
  logic [6:0]       width_q;
  logic [5:0]       prec_q;
  logic             sign_on_q;
  logic [7:0]       sign_char_q;

  logic [VAL_W-1:0] ext;
  logic [VAL_W-1:0] mag;
  logic             is_signed;
  logic             neg;
  logic             sign_on;
  logic [7:0]       sign_char;
  radix_t           radix;

  logic [LEN_W-1:0] prec_eff;
  logic [LEN_W-1:0] ndig_l;
  logic [LEN_W-1:0] zeros_l;
  logic [LEN_W-1:0] len_l;
  logic [LEN_W-1:0] w_eff;
  logic [LEN_W-1:0] pad_l;
  logic [LEN_W-1:0] total_l;
  logic             prefix;

  conv_cmd_t        cmd;
  conv_sts_t        sts;
  emit_job_t        job;
  logic             pop;
  logic             busy;
  logic             accept;

  function automatic logic func_ok(input logic [2:0] f);
    return f <= FUNC_PTR;
  endfunction

  assign accept = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Requests with an unknown conversion are taken and produce no characters.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (req.valid && func_ok(req.func)) state_next = ST_PREP;
      ST_PREP:  state_next = ST_CONV;
      ST_CONV:  if (sts.bits_done) state_next = ST_NORM;
      ST_NORM:  if (sts.norm_done) state_next = ST_SETUP;
      ST_SETUP: state_next = ST_EMIT;
      ST_EMIT:  if (!busy) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    cmd       = '0;
    case (state)
      ST_IDLE:  req.ready = 1'b1;
      ST_PREP:  cmd.load = 1'b1;
      ST_CONV:  cmd.conv = 1'b1;
      ST_NORM:  cmd.norm = 1'b1;
      default:  req.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_q     <= req.value;
      func_q      <= req.func;
      size_q      <= req.size_kind;
      sign_mode_q <= req.sign_mode;
      alt_q       <= req.alt_form;
      left_q      <= req.left_adjust;
      fill_q      <= req.zero_fill;
      width_q     <= req.width;
      prec_q      <= req.precision;
    end
    if (state == ST_PREP) begin
      sign_on_q   <= sign_on;
      sign_char_q <= sign_char;
    end
  end

  // Cut the value to its size, sign-extend for signed decimal, and take the
  // magnitude of a negative value from the extended word.
  always_comb begin
    is_signed = (func_q == FUNC_DEC);
    if (func_q == FUNC_PTR) begin
      ext = value_q;
    end else begin
      case (size_q)
        SIZE_CHAR:  ext = {{(VAL_W-8){is_signed & value_q[7]}}, value_q[7:0]};
        SIZE_SHORT: ext = {{(VAL_W-16){is_signed & value_q[15]}}, value_q[15:0]};
        SIZE_INT:   ext = {{(VAL_W-32){is_signed & value_q[31]}}, value_q[31:0]};
        default:    ext = value_q;
      endcase
    end
    neg     = is_signed & ext[VAL_W-1];
    mag     = neg ? (~ext + VAL_W'(1)) : ext;
    sign_on = neg | (is_signed & (sign_mode_q != SIGN_NONE));
    if (neg) begin
      sign_char = CH_MINUS;
    end else if (sign_mode_q[SIGN_PLUS_BIT]) begin
      sign_char = CH_PLUS;
    end else begin
      sign_char = CH_SPACE;
    end
  end

  always_comb begin
    case (func_q) inside
      FUNC_DEC, FUNC_UNS: radix = RADIX_10;
      FUNC_OCT:           radix = RADIX_8;
      default:            radix = RADIX_16;
    endcase
  end

  // Field sizing, once the significant digit count is known.
  always_comb begin
    if (prec_q == 6'd0) begin
      prec_eff = LEN_W'(1);
    end else if (LEN_W'(prec_q) > LEN_W'(MAX_PRECISION)) begin
      prec_eff = LEN_W'(MAX_PRECISION);
    end else begin
      prec_eff = LEN_W'(prec_q);
    end
    ndig_l  = LEN_W'(sts.ndig);
    zeros_l = (prec_eff > ndig_l) ? prec_eff - ndig_l : '0;
    // Octal alternate form needs a leading zero only when none is there yet.
    if (func_q == FUNC_OCT && alt_q && zeros_l == '0) begin
      zeros_l = LEN_W'(1);
    end
    prefix = ((func_q == FUNC_HEX_LO || func_q == FUNC_HEX_UP) && alt_q)
             || (func_q == FUNC_PTR);
    len_l   = zeros_l + ndig_l + LEN_W'(sign_on_q) + (prefix ? LEN_W'(2) : '0);
    w_eff   = (LEN_W'(width_q) > LEN_W'(MAX_WIDTH)) ? LEN_W'(MAX_WIDTH) : LEN_W'(width_q);
    pad_l   = (w_eff > len_l) ? w_eff - len_l : '0;
    total_l = len_l + pad_l;
  end

  assign job.load      = (state == ST_SETUP);
  assign job.left      = left_q;
  assign job.fill_zero = fill_q;
  assign job.sign_on   = sign_on_q;
  assign job.sign_char = sign_char_q;
  assign job.prefix    = prefix;
  assign job.upper     = (func_q != FUNC_HEX_LO);
  assign job.ndig      = sts.ndig;

  itf_conv u_conv (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .pop   (pop),
    .radix (radix),
    .mag   (mag),
    .sts   (sts)
  );

  itf_emit #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_PRECISION (MAX_PRECISION)
  ) u_emit (
    .clk   (clk),
    .rst   (rst),
    .job   (job),
    .zeros (zeros_l[ZW-1:0]),
    .pad   (pad_l),
    .total (total_l),
    .digit (sts.top_digit),
    .pop   (pop),
    .busy  (busy),
    .chr   (chars)
  );

endmodule

/* hdl/itf_check.sv */
module itf_check import itf_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [2:0] in_func,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last
);

  // A character that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("output item changed while stalled");

  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // A known conversion keeps the block busy after it is taken.
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_func <= FUNC_PTR |=> !in_ready)
    else $error("request taken while a field is in progress");

  // A new request cannot produce a character in the very next cycle.
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("character appeared too early");

  // Mid-field the block takes no new request.
  a_mid_field: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |-> !in_ready)
    else $error("ready for a request in the middle of a field");

endmodule

bind integer_to_text_formatter itf_check u_itf_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .in_func   (req.func),
  .out_valid (chars.valid),
  .out_ready (chars.ready),
  .out_char  (chars.out_char),
  .out_last  (chars.last)
);

/* dv/integer_to_text_formatter_tb.sv */
`timescale 1ns / 100ps

import itf_pkg::*;

typedef struct {
  logic [63:0] value;
  logic [2:0]  func;
  logic [2:0]  size_kind;
  logic [1:0]  sign_mode;
  logic        alt_form;
  logic        left_adjust;
  logic        zero_fill;
  logic [6:0]  width;
  logic [5:0]  precision;
} fmt_req_t;

typedef struct {
  logic [7:0] ch;
  logic       last;
} field_char_t;

class text_scoreboard;
  field_char_t expected_chars[$];
  int          mismatches;
  string       digits_upper = "0123456789ABCDEF";
  string       digits_lower = "0123456789abcdef";

  function new();
    mismatches = 0;
  endfunction

  // Builds the full field for one request and queues its characters.
  function void note_request(fmt_req_t r);
    logic [63:0] mag;
    logic [63:0] mask;
    logic [63:0] radix;
    logic [7:0]  sign_ch;
    logic [7:0]  fill_ch;
    logic [7:0]  txt[$];
    int          nbits;
    int          prec;
    int          fw;
    int          pad;
    int          d;
    bit          upper;
    bit          prefix;
    field_char_t fc;

    if (r.func > FUNC_PTR) return;

    nbits = 64;
    if (r.func != FUNC_PTR) begin
      case (r.size_kind)
        SIZE_CHAR:  nbits = 8;
        SIZE_SHORT: nbits = 16;
        SIZE_INT:   nbits = 32;
        default:    nbits = 64;
      endcase
    end

    mag = r.value;
    if (nbits < 64) begin
      mask = (64'd1 << nbits) - 64'd1;
      mag &= mask;
      if (r.func == FUNC_DEC && mag[nbits-1]) mag |= ~mask;
    end

    sign_ch = 8'd0;
    if (r.func == FUNC_DEC) begin
      if (mag[63]) begin
        sign_ch = CH_MINUS;
        mag = -mag;
      end else if (r.sign_mode[SIGN_PLUS_BIT]) begin
        sign_ch = CH_PLUS;
      end else if (r.sign_mode[SIGN_SPACE_BIT]) begin
        sign_ch = CH_SPACE;
      end
    end

    if (r.func == FUNC_DEC || r.func == FUNC_UNS) radix = 64'd10;
    else if (r.func == FUNC_OCT) radix = 64'd8;
    else radix = 64'd16;
    upper = (r.func != FUNC_HEX_LO);
    prefix = r.alt_form || (r.func == FUNC_PTR);

    prec = r.precision;
    if (prec > MAX_PRECISION_DEF) prec = MAX_PRECISION_DEF;
    if (prec == 0) prec = 1;

    while (mag != 64'd0) begin
      d = int'(mag % radix);
      txt.push_front(upper ? digits_upper[d] : digits_lower[d]);
      mag = mag / radix;
    end
    while (txt.size() < prec) txt.push_front(CH_ZERO);

    if (prefix) begin
      if (radix == 64'd8 && txt[0] != CH_ZERO) begin
        txt.push_front(CH_ZERO);
      end else if (radix == 64'd16) begin
        txt.push_front(upper ? CH_X_UP : CH_X_LO);
        txt.push_front(CH_ZERO);
      end
    end
    if (sign_ch != 8'd0) txt.push_front(sign_ch);

    fw = r.width;
    if (fw > MAX_WIDTH_DEF) fw = MAX_WIDTH_DEF;
    pad = (fw > txt.size()) ? fw - txt.size() : 0;
    fill_ch = r.zero_fill ? CH_ZERO : CH_SPACE;
    // Zero fill still goes in front of the sign, and after the text when left-adjusted.
    repeat (pad) begin
      if (r.left_adjust) txt.push_back(fill_ch);
      else txt.push_front(fill_ch);
    end

    foreach (txt[i]) begin
      fc.ch = txt[i];
      fc.last = (i == txt.size() - 1);
      expected_chars.push_back(fc);
    end
  endfunction

  function void check_char(logic [7:0] ch, logic last);
    field_char_t e;
    if (expected_chars.size() == 0) begin
      $error("out_char: expected none, actual %h", ch);
      mismatches++;
      return;
    end
    e = expected_chars.pop_front();
    if (ch !== e.ch) begin
      $error("out_char: expected %h, actual %h", e.ch, ch);
      mismatches++;
    end
    if (last !== e.last) begin
      $error("last: expected %b, actual %b", e.last, last);
      mismatches++;
    end
  endfunction
endclass

module integer_to_text_formatter_tb;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES     = 120;
  localparam int RANDOM_PER_PHASE = 44;

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   quiet_cycles;
  bit   long_hold_req;
  bit   long_hold_done;

  text_scoreboard sb = new();

  itf_req_if req_bus();
  itf_chr_if chr_bus();

  integer_to_text_formatter dut (
    .clk   (clk),
    .rst   (rst),
    .req   (req_bus),
    .chars (chr_bus)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && req_bus.valid && req_bus.ready) begin
      sb.note_request('{req_bus.value, req_bus.func, req_bus.size_kind, req_bus.sign_mode,
                        req_bus.alt_form, req_bus.left_adjust, req_bus.zero_fill,
                        req_bus.width, req_bus.precision});
    end
    if (!rst && chr_bus.valid && chr_bus.ready) begin
      sb.check_char(chr_bus.out_char, chr_bus.last);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (chr_bus.valid && chr_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL integer_to_text_formatter");
      $finish;
    end
  end

  // The character sink owns its stall pattern, including the one long hold-off.
  initial begin
    chr_bus.ready = 1'b0;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        chr_bus.ready = 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        chr_bus.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic fmt_req_t mk_req(logic [63:0] value, logic [2:0] func,
                                      logic [2:0] size_kind, logic [1:0] sign_mode,
                                      logic alt_form, logic left_adjust, logic zero_fill,
                                      logic [6:0] width, logic [5:0] precision);
    fmt_req_t r;
    r.value = value;
    r.func = func;
    r.size_kind = size_kind;
    r.sign_mode = sign_mode;
    r.alt_form = alt_form;
    r.left_adjust = left_adjust;
    r.zero_fill = zero_fill;
    r.width = width;
    r.precision = precision;
    return r;
  endfunction

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0: v = 64'($urandom_range(20));
      1: v = {32'd0, $urandom};
      2: v = -64'($urandom_range(300));
      3: begin
        case ($urandom_range(3))
          0: v = 64'h8000_0000_0000_0000;
          1: v = '1;
          2: v = 64'h7FFF_FFFF_FFFF_FFFF;
          default: v = 64'd0;
        endcase
      end
      4: begin
        // Values near the sign bit of the 8-, 16- and 32-bit sizes, with random upper bits above it.
        case ($urandom_range(2))
          0: v = {v[63:8], 1'b1, 7'($urandom_range(1) ? 7'h00 : 7'h7F)};
          1: v = {v[63:16], 1'b1, 15'($urandom_range(1) ? 15'h0 : 15'h7FFF)};
          default: v = {v[63:32], 1'b1, 31'($urandom_range(1) ? 31'h0 : 31'h7FFF_FFFF)};
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic fmt_req_t random_request();
    fmt_req_t r;
    r.value = random_value();
    r.func = ($urandom_range(99) < 6) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
    r.size_kind = 3'($urandom_range(7));
    r.sign_mode = 2'($urandom_range(3));
    r.alt_form = 1'($urandom_range(1));
    r.left_adjust = 1'($urandom_range(1));
    r.zero_fill = 1'($urandom_range(1));
    r.width = ($urandom_range(99) < 80) ? 7'($urandom_range(24)) : 7'($urandom_range(127));
    r.precision = ($urandom_range(99) < 80) ? 6'($urandom_range(12)) : 6'($urandom_range(63));
    return r;
  endfunction

  // Called and returns at a falling edge; valid stays high into the next item.
  task automatic offer_request(fmt_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid = 1'b0;
      @(negedge clk);
    end
    req_bus.valid = 1'b1;
    req_bus.value = r.value;
    req_bus.func = r.func;
    req_bus.size_kind = r.size_kind;
    req_bus.sign_mode = r.sign_mode;
    req_bus.alt_form = r.alt_form;
    req_bus.left_adjust = r.left_adjust;
    req_bus.zero_fill = r.zero_fill;
    req_bus.width = r.width;
    req_bus.precision = r.precision;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_random(int count);
    fmt_req_t r;
    int       sent;
    sent = 0;
    while (sent < count) begin
      r = random_request();
      offer_request(r);
      if (r.func <= FUNC_PTR) sent++;
    end
  endtask

  task automatic run_directed();
    offer_request(mk_req(64'd0, FUNC_DEC, SIZE_INT, SIGN_NONE, 1'b0, 1'b0, 1'b0,
                         7'd0, 6'd0));
    offer_request(mk_req(64'h8000_0000_0000_0000, FUNC_DEC, SIZE_LONG, SIGN_NONE,
                         1'b0, 1'b0, 1'b0, 7'd0, 6'd0));
    offer_request(mk_req(64'hFFFF_FFFF, FUNC_DEC, SIZE_INT, SIGN_PLUS, 1'b0, 1'b0, 1'b1,
                         7'd8, 6'd0));
    offer_request(mk_req(64'h80, FUNC_DEC, SIZE_CHAR, SIGN_NONE, 1'b0, 1'b0, 1'b0,
                         7'd5, 6'd0));
    offer_request(mk_req(64'h1234_7FFF, FUNC_DEC, SIZE_SHORT, SIGN_SPACE, 1'b0, 1'b0, 1'b0,
                         7'd0, 6'd0));
    offer_request(mk_req(64'd42, FUNC_DEC, SIZE_INT, SIGN_BOTH, 1'b0, 1'b0, 1'b0,
                         7'd0, 6'd0));
    offer_request(mk_req('1, FUNC_UNS, SIZE_UNKNOWN, SIGN_PLUS, 1'b0, 1'b0, 1'b0,
                         7'd0, 6'd0));
    offer_request(mk_req(64'd0, FUNC_OCT, SIZE_INT, SIGN_NONE, 1'b1, 1'b0, 1'b0,
                         7'd0, 6'd0));
    offer_request(mk_req(64'd8, FUNC_OCT, SIZE_INT, SIGN_NONE, 1'b1, 1'b0, 1'b0,
                         7'd0, 6'd5));
    offer_request(mk_req('1, FUNC_OCT, SIZE_LLONG, SIGN_BOTH, 1'b1, 1'b0, 1'b0,
                         7'd0, 6'd0));
    offer_request(mk_req(64'd0, FUNC_HEX_LO, SIZE_INT, SIGN_NONE, 1'b1, 1'b0, 1'b0,
                         7'd0, 6'd0));
    offer_request(mk_req(64'hDEAD_BEEF, FUNC_HEX_UP, SIZE_INT, SIGN_NONE, 1'b1, 1'b1, 1'b1,
                         7'd20, 6'd0));
    offer_request(mk_req(64'h0123_4567_89AB_CDEF, FUNC_PTR, SIZE_CHAR, SIGN_PLUS,
                         1'b0, 1'b0, 1'b0, 7'd0, 6'd0));
    offer_request(mk_req(64'd0, FUNC_PTR, SIZE_INT, SIGN_NONE, 1'b0, 1'b0, 1'b1,
                         7'd10, 6'd0));
    offer_request(mk_req(64'd77, FUNC_RSVD6, SIZE_INT, SIGN_NONE, 1'b0, 1'b0, 1'b0,
                         7'd10, 6'd0));
    offer_request(mk_req(64'd77, FUNC_RSVD7, SIZE_INT, SIGN_NONE, 1'b0, 1'b0, 1'b0,
                         7'd10, 6'd0));
    offer_request(mk_req(64'd123, FUNC_DEC, SIZE_SIZET, SIGN_PLUS, 1'b0, 1'b1, 1'b0,
                         7'd127, 6'd63));
    offer_request(mk_req('1, FUNC_HEX_LO, SIZE_SIZET, SIGN_NONE, 1'b1, 1'b0, 1'b0,
                         7'd4, 6'd0));
    offer_request(mk_req(64'd9, FUNC_UNS, SIZE_INTMAX, SIGN_NONE, 1'b0, 1'b0, 1'b1,
                         7'd64, 6'd50));
    offer_request(mk_req(64'hFFFF_8000, FUNC_DEC, SIZE_SHORT, SIGN_NONE, 1'b0, 1'b1, 1'b0,
                         7'd30, 6'd10));
    offer_request(mk_req(64'h7FFF_FFFF_FFFF_FFFF, FUNC_DEC, SIZE_INTMAX, SIGN_SPACE,
                         1'b1, 1'b0, 1'b1, 7'd64, 6'd0));
  endtask

  initial begin
    rst = 1'b1;
    long_hold_req = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.value = '0;
    req_bus.func = FUNC_DEC;
    req_bus.size_kind = SIZE_INT;
    req_bus.sign_mode = SIGN_NONE;
    req_bus.alt_form = 1'b0;
    req_bus.left_adjust = 1'b0;
    req_bus.zero_fill = 1'b0;
    req_bus.width = '0;
    req_bus.precision = '0;
    send_idle_pct = 10;
    recv_idle_pct = 73;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    run_random(RANDOM_PER_PHASE);

    send_idle_pct = 73;
    recv_idle_pct = 10;
    run_random(RANDOM_PER_PHASE);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold_req = 1'b1;
    run_random(RANDOM_PER_PHASE);

    req_bus.valid = 1'b0;
    while (sb.expected_chars.size() != 0) @(posedge clk);
    // Any stray character from a dropped request would show up in this window.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("PASS integer_to_text_formatter");
    end else begin
      $display("FAIL integer_to_text_formatter");
    end
    $finish;
  end
endmodule
